// File: hw/rtl/gsl_pkg.sv
// ----------------------------------------------------------------------------
// gsl_pkg
// Shared types, constants and the per-channel operation sequence of the
// global SSIM loss block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsl_pkg;

  localparam int MaxChannelsDef = 4;
  localparam int MaxDimDef      = 1024;

  // register indexes of the configuration port
  localparam logic [1:0] CfgRowsIdx  = 2'd0;
  localparam logic [1:0] CfgColsIdx  = 2'd1;
  localparam logic [1:0] CfgChansIdx = 2'd2;

  localparam int SsimK9   = 9;
  localparam int SsimK10k = 10000;
  localparam int SsimK20k = 20000;

  localparam int          QuoBits  = 18;
  localparam logic [17:0] OneQ16   = 18'd65536;
  localparam logic [17:0] TwoQ16   = 18'd131072;

  localparam int UopW    = 5;
  localparam int NumUops = 18;

  typedef enum logic [3:0] {
    S_ACCUM,
    S_MAC_LOAD,
    S_MAC_RUN,
    S_DIV_LOAD,
    S_DIV_CHECK,
    S_DIV_RUN,
    S_RES,
    S_OUT
  } state_e;

  typedef enum logic [4:0] {
    OP_NS,
    OP_N,
    OP_SP,
    OP_ST,
    OP_SPT,
    OP_SPPT,
    OP_D2,
    OP_PROD,
    OP_T,
    OP_BM,
    OP_SQ,
    OP_A,
    OP_E,
    OP_F,
    OP_K1,
    OP_K9,
    OP_K10K,
    OP_K20K
  } opnd_e;

  typedef enum logic [3:0] {
    DST_NONE,
    DST_D2,
    DST_PROD,
    DST_A,
    DST_T,
    DST_BM,
    DST_SQ,
    DST_E,
    DST_F
  } dst_e;

  typedef struct packed {
    logic  keep;
    logic  sub;
    opnd_e x;
    opnd_e y;
    dst_e  dst;
  } uop_t;

  typedef struct packed {
    logic accum;
    logic clear;
    logic mac_load;
    logic mac_step;
    logic mac_store;
    logic div_load;
    logic div_mean;
    logic div_check;
    logic div_step;
    logic res_add;
    logic chan_next;
    logic out_load;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic last_sample;
    logic chan_last;
    logic mac_idle;
    logic div_done;
  } sts_t;

  // per channel: acc = (keep ? acc : 0) +/- x * y, then optional store
  function automatic uop_t uop_rom(logic [UopW-1:0] idx);
    uop_t u;
    u = '{1'b0, 1'b0, OP_K1, OP_K1, DST_NONE};
    unique case (idx)
      5'd0:    u = '{1'b0, 1'b0, OP_NS,   OP_NS,   DST_D2};
      5'd1:    u = '{1'b0, 1'b0, OP_SP,   OP_ST,   DST_PROD};
      5'd2:    u = '{1'b0, 1'b0, OP_D2,   OP_K1,   DST_NONE};
      5'd3:    u = '{1'b1, 1'b0, OP_PROD, OP_K20K, DST_A};
      5'd4:    u = '{1'b0, 1'b0, OP_SPT,  OP_N,    DST_T};
      5'd5:    u = '{1'b0, 1'b0, OP_D2,   OP_K9,   DST_NONE};
      5'd6:    u = '{1'b1, 1'b0, OP_T,    OP_K20K, DST_NONE};
      5'd7:    u = '{1'b1, 1'b1, OP_PROD, OP_K20K, DST_BM};
      5'd8:    u = '{1'b0, 1'b0, OP_SP,   OP_SP,   DST_NONE};
      5'd9:    u = '{1'b1, 1'b0, OP_ST,   OP_ST,   DST_SQ};
      5'd10:   u = '{1'b0, 1'b0, OP_D2,   OP_K1,   DST_NONE};
      5'd11:   u = '{1'b1, 1'b0, OP_SQ,   OP_K10K, DST_E};
      5'd12:   u = '{1'b0, 1'b0, OP_SPPT, OP_N,    DST_NONE};
      5'd13:   u = '{1'b1, 1'b1, OP_SQ,   OP_K1,   DST_T};
      5'd14:   u = '{1'b0, 1'b0, OP_D2,   OP_K9,   DST_NONE};
      5'd15:   u = '{1'b1, 1'b0, OP_T,    OP_K10K, DST_F};
      5'd16:   u = '{1'b0, 1'b0, OP_A,    OP_BM,   DST_A};
      5'd17:   u = '{1'b0, 1'b0, OP_E,    OP_F,    DST_E};
      default: u = '{1'b0, 1'b0, OP_K1, OP_K1, DST_NONE};
    endcase
    return u;
  endfunction

endpackage

// File: hw/rtl/gsl_ctrl.sv
// ----------------------------------------------------------------------------
// gsl_ctrl
// Sequencer: accumulation phase, per-channel multiply program, divisions,
// channel mean and the output register handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  gsl_pkg::sts_t sts_i,
  output gsl_pkg::cmd_t cmd_o
);
  import gsl_pkg::*;

  state_e            state_q, state_d;
  logic [UopW-1:0]   uop_q, uop_d;
  logic              mean_q, mean_d;
  logic              out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACCUM;
      uop_q       <= '0;
      mean_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      uop_q       <= uop_d;
      mean_q      <= mean_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    uop_d       = uop_q;
    mean_d      = mean_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.uop   = uop_rom(uop_q);
    cmd_o.div_mean = mean_q;

    unique case (state_q)
      S_ACCUM: begin
        in_ready_o  = 1'b1;
        cmd_o.accum = in_valid_i;
        if (in_valid_i && sts_i.last_sample) begin
          uop_d   = '0;
          state_d = S_MAC_LOAD;
        end
      end
      S_MAC_LOAD: begin
        cmd_o.mac_load = 1'b1;
        state_d        = S_MAC_RUN;
      end
      S_MAC_RUN: begin
        cmd_o.mac_step = 1'b1;
        if (sts_i.mac_idle) begin
          cmd_o.mac_store = 1'b1;
          if (uop_q == UopW'(NumUops - 1)) begin
            mean_d  = 1'b0;
            state_d = S_DIV_LOAD;
          end else begin
            uop_d   = uop_q + 1'b1;
            state_d = S_MAC_LOAD;
          end
        end
      end
      S_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = S_DIV_CHECK;
      end
      S_DIV_CHECK: begin
        cmd_o.div_check = 1'b1;
        state_d         = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (!sts_i.div_done) begin
          cmd_o.div_step = 1'b1;
        end else if (mean_q) begin
          state_d = S_OUT;
        end else begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        cmd_o.res_add = 1'b1;
        if (sts_i.chan_last) begin
          mean_d  = 1'b1;
          state_d = S_DIV_LOAD;
        end else begin
          cmd_o.chan_next = 1'b1;
          uop_d           = '0;
          state_d         = S_MAC_LOAD;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clear    = 1'b1;
          state_d        = S_ACCUM;
        end
      end
      default: state_d = S_ACCUM;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/gsl_datapath.sv
// ----------------------------------------------------------------------------
// gsl_datapath
// Per-channel moment accumulators, a bit-serial multiply-accumulate unit
// with its operand registers, a restoring divider and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsl_datapath #(
  parameter int MAX_CHANNELS = gsl_pkg::MaxChannelsDef,
  parameter int MAX_DIM      = gsl_pkg::MaxDimDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [10:0]   cfg_wdata_i,
  input  logic [15:0]   pred_sample_i,
  input  logic [15:0]   truth_sample_i,
  input  gsl_pkg::cmd_t cmd_i,
  output gsl_pkg::sts_t sts_o,
  output logic [17:0]   loss_value_o
);
  import gsl_pkg::*;

  localparam int DimW = $clog2(MAX_DIM + 1);
  localparam int NW   = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int SW   = NW + 16;
  localparam int QW   = NW + 32;
  localparam int HW   = 2 * NW + 48;
  localparam int PW   = 2 * HW;
  localparam int DW   = PW + 16;
  localparam int CHW  = $clog2(MAX_CHANNELS + 1);
  localparam int CIW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int TW   = CHW + 19;
  localparam int DCW  = $clog2(QuoBits + 1);

  // configuration
  logic [10:0] rows_q, cols_q;
  logic [2:0]  chn_q;
  logic        cfg_hit, clr;

  always_comb begin
    unique case (cfg_idx_i)
      CfgRowsIdx, CfgColsIdx, CfgChansIdx: cfg_hit = cfg_we_i;
      default:                             cfg_hit = 1'b0;
    endcase
  end

  assign clr = cfg_hit || cmd_i.clear;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= 11'd1;
      cols_q <= 11'd1;
      chn_q  <= 3'd3;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgRowsIdx)  rows_q <= cfg_wdata_i;
      if (cfg_idx_i == CfgColsIdx)  cols_q <= cfg_wdata_i;
      if (cfg_idx_i == CfgChansIdx) chn_q  <= cfg_wdata_i[2:0];
    end
  end

  logic [DimW-1:0] rows_c, cols_c;
  logic [CHW-1:0]  chc;
  logic [NW-1:0]   n_w;
  logic [NW+15:0]  ns_w;

  always_comb begin
    if (rows_q == '0)                rows_c = DimW'(1);
    else if (32'(rows_q) > MAX_DIM)  rows_c = DimW'(MAX_DIM);
    else                             rows_c = DimW'(rows_q);
    if (cols_q == '0)                cols_c = DimW'(1);
    else if (32'(cols_q) > MAX_DIM)  cols_c = DimW'(MAX_DIM);
    else                             cols_c = DimW'(cols_q);
    if (chn_q == '0)                     chc = CHW'(1);
    else if (32'(chn_q) > MAX_CHANNELS)  chc = CHW'(MAX_CHANNELS);
    else                                 chc = CHW'(chn_q);
  end

  assign n_w  = NW'(rows_c) * NW'(cols_c);
  // 65535 * n
  assign ns_w = {n_w, 16'b0} - (NW + 16)'(n_w);

  // channel position doubles as the channel cursor during the computation
  logic [CIW-1:0] cidx_q, ridx;
  logic [NW-1:0]  pix_q;
  logic           ch_wrap;

  assign ridx    = (32'(cidx_q) >= 32'(chc)) ? '0 : cidx_q;
  assign ch_wrap = (32'(ridx) + 32'd1 >= 32'(chc));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cidx_q <= '0;
      pix_q  <= '0;
    end else if (clr) begin
      cidx_q <= '0;
      pix_q  <= '0;
    end else if (cmd_i.accum) begin
      cidx_q <= ch_wrap ? '0 : ridx + 1'b1;
      if (ch_wrap) pix_q <= pix_q + 1'b1;
    end else if (cmd_i.chan_next) begin
      cidx_q <= cidx_q + 1'b1;
    end
  end

  // moment accumulators
  logic [SW-1:0] sp_q  [MAX_CHANNELS];
  logic [SW-1:0] st_q  [MAX_CHANNELS];
  logic [QW-1:0] spp_q [MAX_CHANNELS];
  logic [QW-1:0] stt_q [MAX_CHANNELS];
  logic [QW-1:0] spt_q [MAX_CHANNELS];
  logic [31:0]   pp_w, tt_w, pt_w;

  assign pp_w = pred_sample_i * pred_sample_i;
  assign tt_w = truth_sample_i * truth_sample_i;
  assign pt_w = pred_sample_i * truth_sample_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sp_q[i]  <= '0;
        st_q[i]  <= '0;
        spp_q[i] <= '0;
        stt_q[i] <= '0;
        spt_q[i] <= '0;
      end
    end else if (clr) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        sp_q[i]  <= '0;
        st_q[i]  <= '0;
        spp_q[i] <= '0;
        stt_q[i] <= '0;
        spt_q[i] <= '0;
      end
    end else if (cmd_i.accum) begin
      sp_q[ridx]  <= sp_q[ridx] + SW'(pred_sample_i);
      st_q[ridx]  <= st_q[ridx] + SW'(truth_sample_i);
      spp_q[ridx] <= spp_q[ridx] + QW'(pp_w);
      stt_q[ridx] <= stt_q[ridx] + QW'(tt_w);
      spt_q[ridx] <= spt_q[ridx] + QW'(pt_w);
    end
  end

  logic [SW-1:0] sp_r, st_r;
  logic [QW-1:0] spp_r, stt_r, spt_r;

  assign sp_r  = sp_q[ridx];
  assign st_r  = st_q[ridx];
  assign spp_r = spp_q[ridx];
  assign stt_r = stt_q[ridx];
  assign spt_r = spt_q[ridx];

  // operand registers of the per-channel program
  logic [HW-1:0] d2_q, prod_q, t_q, bm_q, sq_q, f_q;
  logic [PW-1:0] a_q, e_q;
  logic          neg_q;

  function automatic logic [HW-1:0] pick(opnd_e sel, logic [NW-1:0] n,
                                         logic [NW+15:0] ns,
                                         logic [SW-1:0] sp, logic [SW-1:0] st,
                                         logic [QW-1:0] spt, logic [HW-1:0] sppt,
                                         logic [HW-1:0] d2, logic [HW-1:0] prod,
                                         logic [HW-1:0] t, logic [HW-1:0] bm,
                                         logic [HW-1:0] sq, logic [HW-1:0] a,
                                         logic [HW-1:0] e, logic [HW-1:0] f);
    logic [HW-1:0] v;
    unique case (sel)
      OP_NS:   v = HW'(ns);
      OP_N:    v = HW'(n);
      OP_SP:   v = HW'(sp);
      OP_ST:   v = HW'(st);
      OP_SPT:  v = HW'(spt);
      OP_SPPT: v = sppt;
      OP_D2:   v = d2;
      OP_PROD: v = prod;
      OP_T:    v = t;
      OP_BM:   v = bm;
      OP_SQ:   v = sq;
      OP_A:    v = a;
      OP_E:    v = e;
      OP_F:    v = f;
      OP_K1:   v = HW'(1);
      OP_K9:   v = HW'(SsimK9);
      OP_K10K: v = HW'(SsimK10k);
      OP_K20K: v = HW'(SsimK20k);
      default: v = '0;
    endcase
    return v;
  endfunction

  logic [HW-1:0] sppt_w, x_w, y_w;

  assign sppt_w = HW'(spp_r) + HW'(stt_r);
  assign x_w = pick(cmd_i.uop.x, n_w, ns_w, sp_r, st_r, spt_r, sppt_w, d2_q, prod_q,
                    t_q, bm_q, sq_q, a_q[HW-1:0], e_q[HW-1:0], f_q);
  assign y_w = pick(cmd_i.uop.y, n_w, ns_w, sp_r, st_r, spt_r, sppt_w, d2_q, prod_q,
                    t_q, bm_q, sq_q, a_q[HW-1:0], e_q[HW-1:0], f_q);

  // bit-serial multiply-accumulate, one multiplier bit per cycle
  logic [PW:0]   acc_q;
  logic [PW-1:0] mcd_q;
  logic [HW-1:0] mpl_q;
  logic          sub_q;
  logic [PW-1:0] acc_abs;

  assign acc_abs = acc_q[PW] ? PW'(-acc_q) : acc_q[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_load) begin
      if (!cmd_i.uop.keep) acc_q <= '0;
      mcd_q <= PW'(x_w);
      mpl_q <= y_w;
      sub_q <= cmd_i.uop.sub;
    end else if (cmd_i.mac_step && mpl_q != '0) begin
      if (mpl_q[0]) acc_q <= sub_q ? acc_q - {1'b0, mcd_q} : acc_q + {1'b0, mcd_q};
      mcd_q <= mcd_q << 1;
      mpl_q <= mpl_q >> 1;
    end
    if (cmd_i.mac_store) begin
      unique case (cmd_i.uop.dst)
        DST_NONE: ;
        DST_D2:   d2_q   <= HW'(acc_abs);
        DST_PROD: prod_q <= HW'(acc_abs);
        DST_A:    a_q    <= acc_abs;
        DST_T:    t_q    <= HW'(acc_abs);
        DST_BM: begin
          bm_q  <= HW'(acc_abs);
          neg_q <= acc_q[PW];
        end
        DST_SQ:   sq_q   <= HW'(acc_abs);
        DST_E:    e_q    <= acc_abs;
        DST_F:    f_q    <= HW'(acc_abs);
        default:  ;
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [TW-1:0]      tot_q;
  logic [TW-1:0]      mean_num;
  logic [DW-1:0]      dvd_w;
  logic [PW:0]        rem_q, trial;
  logic [QuoBits-1:0] dlo_q, quo_q;
  logic [PW-1:0]      dsr_q;
  logic [DCW-1:0]     dcnt_q;
  logic               sat_q;

  assign mean_num = tot_q + (TW'(chc) << 16);
  assign dvd_w    = cmd_i.div_mean ? DW'(mean_num) : {a_q, 16'b0};
  assign trial    = {rem_q[PW-1:0], dlo_q[QuoBits-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= (PW + 1)'(dvd_w >> QuoBits);
      dlo_q <= dvd_w[QuoBits-1:0];
      dsr_q <= cmd_i.div_mean ? PW'(chc) : e_q;
      quo_q <= '0;
      sat_q <= 1'b0;
    end else if (cmd_i.div_check) begin
      // quotient does not fit the fraction width: saturates
      sat_q <= (rem_q >= {1'b0, dsr_q});
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_q <= trial - {1'b0, dsr_q};
        quo_q <= {quo_q[QuoBits-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[QuoBits-2:0], 1'b0};
      end
      dlo_q <= dlo_q << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_load) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  // channel ssim: floor toward minus infinity, saturated to +-1.0
  logic [17:0]   mag, mag2;
  logic [TW-1:0] res_w;

  always_comb begin
    mag  = (sat_q || quo_q > OneQ16) ? OneQ16 : quo_q;
    mag2 = (neg_q && !sat_q && (|rem_q) && mag != OneQ16) ? mag + 18'd1 : mag;
    res_w = neg_q ? -TW'(mag2) : TW'(mag2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q <= '0;
    end else if (clr) begin
      tot_q <= '0;
    end else if (cmd_i.res_add) begin
      tot_q <= tot_q + res_w;
    end
  end

  logic [17:0] loss_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) loss_q <= TwoQ16 - quo_q;
  end

  assign loss_value_o      = loss_q;
  assign sts_o.last_sample = ch_wrap && (pix_q == n_w - 1'b1);
  assign sts_o.chan_last   = ch_wrap;
  assign sts_o.mac_idle    = (mpl_q == '0);
  assign sts_o.div_done    = (dcnt_q == DCW'(QuoBits));

endmodule

// File: hw/rtl/global_ssim_loss_core.sv
// ----------------------------------------------------------------------------
// global_ssim_loss_core
// Whole-image SSIM loss over a streamed pair of images.
// Samples are taken one per cycle while the image accumulates.
// After the last sample, each channel runs its multiply program on the
// one-bit-per-cycle serial multiply unit, so its time grows with the bit
// lengths of the operands, then a division; the mean is one more division.
// Reset is asynchronous, active low; configuration resets to 1 x 1, 3 channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module global_ssim_loss_core #(
  parameter int MAX_CHANNELS = gsl_pkg::MaxChannelsDef,
  parameter int MAX_DIM      = gsl_pkg::MaxDimDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] pred_sample_i,
  input  logic [15:0] truth_sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [17:0] loss_value_o
);
  import gsl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gsl_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_DIM      (MAX_DIM)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pred_sample_i  (pred_sample_i),
    .truth_sample_i (truth_sample_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .loss_value_o   (loss_value_o)
  );

endmodule

// File: hw/rtl/gsl_checker.sv
// ----------------------------------------------------------------------------
// gsl_checker
// Port-level checks of the global SSIM loss block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [17:0] loss_value_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(loss_value_o))
    else $error("result item changed while stalled");

  a_loss_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> loss_value_o <= 18'd131072)
    else $error("loss above two");

  // a result needs the full computation after the last item of an image
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result right after an input item");

endmodule

bind global_ssim_loss_core gsl_checker u_gsl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .loss_value_o (loss_value_o)
);

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streams image pairs into global_ssim_loss_core under several image shapes
// and channel counts, with random gaps on both handshakes. Each accepted
// sample updates a local copy of the per-channel sums. At the end of an image
// the expected loss is computed with exact wide-integer arithmetic and
// checked against the block's output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import gsl_pkg::*;

  localparam int WatchLimit = 40000;
  localparam int HoldCycles = 400;
  localparam int SettleCycles = 60;

  typedef logic [255:0] wide_t;
  typedef struct packed {
    logic [15:0] pred;
    logic [15:0] truth;
  } sample_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgRowsIdx;
  logic [10:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] pred_sample_i = '0;
  logic [15:0] truth_sample_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [17:0] loss_value_o;

  global_ssim_loss_core dut (.*);

  always #4 clk_i = ~clk_i;

  sample_t     pending_q[$];
  logic [17:0] loss_q[$];
  int          errors = 0;
  int          items_sent = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  bit          in_took = 1'b0;
  int          quiet_cycles = 0;

  // local copy of registers and image state
  logic [10:0]       rows_reg = 11'd1, cols_reg = 11'd1;
  logic [2:0]        chans_reg = 3'd3;
  longint unsigned   acc_p[4], acc_t[4], acc_pp[4], acc_tt[4], acc_pt[4];
  int unsigned       taken = 0;
  int unsigned       chan_pos = 0;

  task automatic report(input string what, input logic [17:0] got, input logic [17:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic void clear_image();
    for (int c = 0; c < 4; c++) begin
      acc_p[c] = 0; acc_t[c] = 0; acc_pp[c] = 0; acc_tt[c] = 0; acc_pt[c] = 0;
    end
    taken = 0;
    chan_pos = 0;
  endfunction

  function automatic longint unsigned clamp_dim(longint unsigned v, longint unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // channel ssim floored to signed q1.16
  function automatic int channel_ssim(longint unsigned n, longint unsigned sp,
                                      longint unsigned st, longint unsigned spp,
                                      longint unsigned stt, longint unsigned spt);
    wide_t wn, d2, prod, a, pos, neg, bm, sq, e, f, num, den, quo, rem, x;
    bit neg_sign, sat;
    int res;
    wn = n;
    x = 65535 * wn;
    d2 = x * x;
    prod = wide_t'(sp) * wide_t'(st);
    a = prod * 20000 + d2;
    pos = wide_t'(spt) * wn * 20000 + d2 * 9;
    neg = prod * 20000;
    neg_sign = pos < neg;
    bm = neg_sign ? neg - pos : pos - neg;
    sq = wide_t'(sp) * wide_t'(sp) + wide_t'(st) * wide_t'(st);
    e = sq * 10000 + d2;
    f = ((wide_t'(spp) + wide_t'(stt)) * wn - sq) * 10000 + d2 * 9;
    num = a * bm * 65536;
    den = e * f;
    if (den == 0) return 0;
    quo = num / den;
    rem = num % den;
    sat = (quo >> 20) != 0;
    if (sat || quo > 65536) quo = 65536;
    if (!neg_sign) return int'(quo);
    res = -int'(quo);
    if (!sat && rem != 0) res -= 1;
    if (res < -65536) res = -65536;
    return res;
  endfunction

  function automatic void take_sample(sample_t s);
    longint unsigned rows, cols, ch, n, pv, tv;
    int unsigned idx;
    int total, avg;
    rows = clamp_dim(rows_reg, 1024);
    cols = clamp_dim(cols_reg, 1024);
    ch = clamp_dim(chans_reg, 4);
    n = rows * cols;
    pv = s.pred;
    tv = s.truth;
    idx = (chan_pos >= ch) ? 0 : chan_pos;
    acc_p[idx] += pv;
    acc_t[idx] += tv;
    acc_pp[idx] += pv * pv;
    acc_tt[idx] += tv * tv;
    acc_pt[idx] += pv * tv;
    chan_pos = (idx + 1 >= ch) ? 0 : idx + 1;
    taken++;
    if (taken < n * ch) return;
    total = 0;
    for (int c = 0; c < ch; c++)
      total += channel_ssim(n, acc_p[c], acc_t[c], acc_pp[c], acc_tt[c], acc_pt[c]);
    avg = (total + 65536 * int'(ch)) / int'(ch) - 65536;
    loss_q.push_back(18'(65536 - avg));
    clear_image();
  endfunction

  // input side
  always @(posedge clk_i) begin
    in_took = in_valid_i && in_ready_o;
    if (in_took) take_sample('{pred_sample_i, truth_sample_i});
  end

  always @(negedge clk_i) begin
    if (!in_valid_i || in_took) begin
      if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 33)) begin
        sample_t s;
        s = pending_q.pop_front();
        in_valid_i <= 1'b1;
        pred_sample_i <= s.pred;
        truth_sample_i <= s.truth;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_ready_i <= 1'b0;
      hold_left <= HoldCycles;
      hold_req = 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (loss_q.size() == 0) begin
        report("unexpected loss", loss_value_o, 18'd0);
      end else begin
        logic [17:0] want;
        want = loss_q.pop_front();
        if (loss_value_o !== want) report("loss_value", loss_value_o, want);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    case (idx)
      CfgRowsIdx:  rows_reg = val;
      CfgColsIdx:  cols_reg = val;
      CfgChansIdx: chans_reg = val[2:0];
      default: ;
    endcase
    clear_image();
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    s.pred = 16'($urandom);
    s.truth = 16'($urandom);
    case ($urandom_range(0, 7))
      0: s.pred = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1: s.truth = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2, 3: s.truth = s.pred;
      4: s.truth = ~s.pred;
      5: s.truth = s.pred + 16'($urandom_range(0, 255));
      default: ;
    endcase
    return s;
  endfunction

  task automatic push(input logic [15:0] p, input logic [15:0] t);
    pending_q.push_back('{p, t});
    items_sent++;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || loss_q.size() != 0);
    // a partial image leaves the block mid-image with no result to wait for
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic image_phase(input logic [10:0] r, input logic [10:0] c,
                             input logic [10:0] ch, input int images, input bit partial);
    int per_image;
    write_reg(CfgRowsIdx, r);
    write_reg(CfgColsIdx, c);
    write_reg(CfgChansIdx, ch);
    @(posedge clk_i);
    per_image = int'(clamp_dim(r, 1024) * clamp_dim(c, 1024) * clamp_dim(ch[2:0], 4));
    for (int i = 0; i < images * per_image; i++) begin
      sample_t s;
      s = random_sample();
      push(s.pred, s.truth);
    end
    if (partial)
      repeat ($urandom_range(1, per_image)) push(16'($urandom), 16'($urandom));
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    clear_image();
    @(posedge clk_i);

    // reset shape 1 x 1 x 3
    push(16'h0000, 16'h0000);
    push(16'hFFFF, 16'hFFFF);
    push(16'hFFFF, 16'h0000);
    drain();

    // single-sample images: all-zero, full scale, opposite extremes, complementary bits
    write_reg(CfgRowsIdx, 11'd1);
    write_reg(CfgColsIdx, 11'd1);
    write_reg(CfgChansIdx, 11'd1);
    @(posedge clk_i);
    push(16'h0000, 16'h0000);
    push(16'hFFFF, 16'hFFFF);
    push(16'h0000, 16'hFFFF);
    push(16'hFFFF, 16'h0000);
    push(16'hAAAA, 16'h5555);
    drain();

    // anticorrelated and identical 2-pixel images
    write_reg(CfgColsIdx, 11'd2);
    @(posedge clk_i);
    push(16'h0000, 16'hFFFF);
    push(16'hFFFF, 16'h0000);
    push(16'h1234, 16'h1234);
    push(16'hFEDC, 16'hFEDC);
    drain();

    // zero registers count as one; a write mid-image restarts it
    image_phase(11'd0, 11'd0, 11'd0, 3, 1'b0);
    image_phase(11'd2, 11'd2, 11'd4, 1, 1'b1);
    // out-of-range values saturate (a 1 x 64 image in between)
    image_phase(11'd2047, 11'd1, 11'd1, 1, 1'b0);
    image_phase(11'd1, 11'd64, 11'd1, 1, 1'b0);
    image_phase(11'd2, 11'd3, 11'd7, 2, 1'b0);

    // receiver holds off while single-sample images pile up
    calm = 1'b1;
    hold_req = 1'b1;
    image_phase(11'd1, 11'd1, 11'd1, 40, 1'b0);
    calm = 1'b0;

    while (items_sent < 1700)
      image_phase(11'($urandom_range(1, 4)), 11'($urandom_range(1, 4)),
                  11'($urandom_range(1, 4)), $urandom_range(1, 5),
                  $urandom_range(0, 5) == 0);

    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
